// ===== sv/assert_macros.svh =====
// assertion macros used by texture_mip_chain_layout_unit
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define TMCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define TMCL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tmcl_pkg.sv =====
// types, constants and format tables for the mip chain layout unit
// no dependencies
package tmcl_pkg;

    localparam int DIM_W   = 15;
    localparam int LAYER_W = 12;
    localparam int BYTES_W = 60;
    localparam int LVL_W   = 4;
    localparam int CNT_W   = 5;
    localparam int BPB_W   = 5;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 64;
    localparam int OFF_W   = 62;

    localparam logic [5:0] NUM_FORMATS  = 6'd35;
    localparam logic [5:0] FMT_BC_FIRST = 6'd27;
    localparam logic [5:0] FMT_BC_LAST  = 6'd32;

    typedef logic [DIM_W-1:0] dim_t;

    // bytes per block, zero for unknown codes
    function automatic logic [BPB_W-1:0] fmt_bytes(input logic [5:0] fmt);
        logic [BPB_W-1:0] b;
        unique case (fmt)
            6'd0, 6'd3:                                   b = 5'd1;
            6'd1, 6'd4, 6'd6, 6'd14, 6'd18:               b = 5'd2;
            6'd2, 6'd5, 6'd7, 6'd10, 6'd15, 6'd19, 6'd22,
            6'd26, 6'd34:                                 b = 5'd4;
            6'd8, 6'd16, 6'd20:                           b = 5'd6;
            6'd9, 6'd11, 6'd17, 6'd21, 6'd23, 6'd33:      b = 5'd8;
            6'd12, 6'd24:                                 b = 5'd12;
            6'd13, 6'd25, 6'd27, 6'd28, 6'd29, 6'd30,
            6'd31, 6'd32:                                 b = 5'd16;
            default:                                      b = 5'd0;
        endcase
        return b;
    endfunction

    // floor(log2(mx)) + 1, one level for a zero maximum
    function automatic logic [CNT_W-1:0] level_count(input dim_t mx);
        logic [CNT_W-1:0] n;
        n = 5'd1;
        for (int i = 0; i < DIM_W; i++) begin
            if (mx[i]) begin
                n = CNT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== sv/tmcl_mul.sv =====
// shared 32x32 multiplier with a registered product
// depends on tmcl_pkg
module tmcl_mul
    import tmcl_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/texture_mip_chain_layout_unit.sv =====
// mip chain layout: one descriptor in, one record per mip level out
// depends on tmcl_pkg, tmcl_mul and assert_macros.svh
//
// Usage:
//   desc channel (desc_valid/desc_ready) takes one texture descriptor:
//   format, width, height, depth, layer_count, buffer_bytes.
//   rec channel (rec_valid/rec_ready) returns one record per mip level, in
//   level order, with last_level set on the final record of the run.
//   Each level goes through a small sequencer that reuses one 32x32
//   multiplier five times (block area, depth times block bytes, layer size,
//   block bytes times depth and layers, level span), then one add and compare
//   for the offset, then the load of the output register. A descriptor yields
//   at most MAX_LEVELS records. desc_ready is high only while no descriptor
//   is in work; the last record may still wait in the output register when
//   the next descriptor is taken.
//   If the receiver stalls, the finished record holds in the output
//   register and the sequencer waits at its emit step until it is taken.
//   Reset (rst_n low, asynchronous) drops any run in progress and any
//   pending record and returns the block to idle.
`include "assert_macros.svh"

module texture_mip_chain_layout_unit
    import tmcl_pkg::*;
#(
    parameter int MAX_LEVELS = 15
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               desc_valid,
    output logic               desc_ready,
    input  logic [5:0]         format,
    input  logic [DIM_W-1:0]   width,
    input  logic [DIM_W-1:0]   height,
    input  logic [DIM_W-1:0]   depth,
    input  logic [LAYER_W-1:0] layer_count,
    input  logic [BYTES_W-1:0] buffer_bytes,
    output logic               rec_valid,
    input  logic               rec_ready,
    output logic [LVL_W-1:0]   mip_level,
    output logic [BYTES_W-1:0] byte_offset,
    output logic [DIM_W-1:0]   level_width,
    output logic [DIM_W-1:0]   level_height,
    output logic [DIM_W-1:0]   level_depth,
    output logic [BYTES_W-1:0] level_bytes,
    output logic               bad_format,
    output logic               last_level
);

    localparam logic [CNT_W-1:0] LVL_CAP = CNT_W'(MAX_LEVELS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_ADD,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    dim_t                 w_reg;
    dim_t                 h_reg;
    dim_t                 d_reg;
    logic [LAYER_W-1:0]   layers_reg;
    logic [BYTES_W-1:0]   buf_reg;
    logic [BPB_W-1:0]     bpb_reg;
    logic                 blk_reg;
    logic                 bad_reg;
    logic [CNT_W-1:0]     levels_reg;
    logic [LVL_W-1:0]     lvl_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [OFF_W-1:0]     acc_reg;
    logic                 stop_reg;
    logic [2*DIM_W-1:0]   area_reg;
    logic [DIM_W+BPB_W-1:0] t_reg;
    logic [BYTES_W-1:0]   sz_reg;

    logic                 rec_valid_reg;
    logic [LVL_W-1:0]     mip_level_reg;
    logic [BYTES_W-1:0]   byte_offset_reg;
    dim_t                 level_width_reg;
    dim_t                 level_height_reg;
    dim_t                 level_depth_reg;
    logic [BYTES_W-1:0]   level_bytes_reg;
    logic                 bad_format_reg;
    logic                 last_level_reg;

    dim_t                 mx;
    logic [CNT_W-1:0]     nat_levels;
    dim_t                 bx;
    dim_t                 by;
    dim_t                 dd;
    logic [MUL_W-1:0]     op_a;
    logic [MUL_W-1:0]     op_b;
    logic [PROD_W-1:0]    prod;
    logic [OFF_W-1:0]     acc_next;
    logic                 stop_next;
    logic                 out_free;

    tmcl_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb
    begin
        mx = width;
        if (height > mx) begin
            mx = height;
        end
        if (depth > mx) begin
            mx = depth;
        end
        nat_levels = level_count(mx);
    end

    // block counts round up for the 4x4 compressed formats
    assign bx = blk_reg ? DIM_W'((16'(w_reg) + 16'd3) >> 2) : w_reg;
    assign by = blk_reg ? DIM_W'((16'(h_reg) + 16'd3) >> 2) : h_reg;
    assign dd = (d_reg == '0) ? DIM_W'(1) : d_reg;

    // operand select; the M3 and M5 steps take as an operand the product issued by the step before
    always_comb
    begin
        unique case (state_reg)
            ST_M1:
            begin
                op_a = MUL_W'(bx);
                op_b = MUL_W'(by);
            end
            ST_M2:
            begin
                op_a = MUL_W'(dd);
                op_b = MUL_W'(bpb_reg);
            end
            ST_M3:
            begin
                op_a = MUL_W'(area_reg);
                op_b = MUL_W'(prod[DIM_W+BPB_W-1:0]);
            end
            ST_M4:
            begin
                op_a = MUL_W'(t_reg);
                op_b = MUL_W'(layers_reg);
            end
            ST_M5:
            begin
                op_a = MUL_W'(area_reg);
                op_b = prod[MUL_W-1:0];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign acc_next  = off_reg + prod[OFF_W-1:0];
    assign stop_next = (acc_next >= OFF_W'(buf_reg))
                     || ((CNT_W'(lvl_reg) + 5'd1) >= levels_reg);
    assign out_free  = !rec_valid_reg || rec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            rec_valid_reg <= 1'b0;
        end else begin
            // the emit step reloads the output register itself
            if (rec_valid_reg && rec_ready && (state_reg != ST_EMIT)) begin
                rec_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (desc_valid) begin
                        w_reg      <= width;
                        h_reg      <= height;
                        d_reg      <= depth;
                        layers_reg <= layer_count;
                        buf_reg    <= buffer_bytes;
                        bpb_reg    <= fmt_bytes(format);
                        blk_reg    <= (format >= FMT_BC_FIRST) && (format <= FMT_BC_LAST);
                        bad_reg    <= (format >= NUM_FORMATS);
                        levels_reg <= (nat_levels > LVL_CAP) ? LVL_CAP : nat_levels;
                        lvl_reg    <= '0;
                        off_reg    <= '0;
                        state_reg  <= ST_M1;
                    end
                end
                ST_M1:
                begin
                    state_reg <= ST_M2;
                end
                ST_M2:
                begin
                    area_reg  <= prod[2*DIM_W-1:0];
                    state_reg <= ST_M3;
                end
                ST_M3:
                begin
                    t_reg     <= prod[DIM_W+BPB_W-1:0];
                    state_reg <= ST_M4;
                end
                ST_M4:
                begin
                    sz_reg    <= prod[BYTES_W-1:0];
                    state_reg <= ST_M5;
                end
                ST_M5:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    acc_reg   <= acc_next;
                    stop_reg  <= stop_next;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free) begin
                        rec_valid_reg    <= 1'b1;
                        mip_level_reg    <= lvl_reg;
                        byte_offset_reg  <= off_reg[BYTES_W-1:0];
                        level_width_reg  <= w_reg;
                        level_height_reg <= h_reg;
                        level_depth_reg  <= d_reg;
                        level_bytes_reg  <= sz_reg;
                        bad_format_reg   <= bad_reg;
                        last_level_reg   <= stop_reg;
                        off_reg          <= acc_reg;
                        lvl_reg          <= lvl_reg + 4'd1;
                        // halve each dimension, never below one
                        w_reg <= (w_reg[DIM_W-1:1] == '0) ? DIM_W'(1) : (w_reg >> 1);
                        h_reg <= (h_reg[DIM_W-1:1] == '0) ? DIM_W'(1) : (h_reg >> 1);
                        d_reg <= (d_reg[DIM_W-1:1] == '0) ? DIM_W'(1) : (d_reg >> 1);
                        state_reg <= stop_reg ? ST_IDLE : ST_M1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign desc_ready   = (state_reg == ST_IDLE);
    assign rec_valid    = rec_valid_reg;
    assign mip_level    = mip_level_reg;
    assign byte_offset  = byte_offset_reg;
    assign level_width  = level_width_reg;
    assign level_height = level_height_reg;
    assign level_depth  = level_depth_reg;
    assign level_bytes  = level_bytes_reg;
    assign bad_format   = bad_format_reg;
    assign last_level   = last_level_reg;

    `TMCL_ASSERT(a_busy_after_accept, desc_valid && desc_ready |=> !desc_ready, "descriptor accepted while busy")
    `TMCL_ASSERT(a_bad_zero_bytes, rec_valid && bad_format |-> level_bytes == '0, "invalid format with nonzero size")
    `TMCL_ASSERT(a_base_offset_zero, rec_valid && mip_level == '0 |-> byte_offset == '0, "base level offset not zero")
    `TMCL_ASSERT_ALWAYS(a_no_rec_in_reset, !rst_n |=> !rec_valid, "record valid during reset")

endmodule

// ===== sim/texture_mip_chain_layout_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench for texture_mip_chain_layout_unit: random and directed descriptors,
// records checked against a level-by-level layout predictor kept in a scoreboard
// depends on tmcl_pkg and texture_mip_chain_layout_unit
module texture_mip_chain_layout_unit_tb;
    import tmcl_pkg::*;

    localparam int MAX_LEVELS  = 15;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 120;
    localparam int RANDOM_DESC = 250;

    localparam logic [5:0] FMT_UNORM8   = 6'd0;
    localparam logic [5:0] FMT_UNORM8X2 = 6'd1;
    localparam logic [5:0] FMT_UNORM8X4 = 6'd2;
    localparam logic [5:0] FMT_SNORM8   = 6'd3;
    localparam logic [5:0] FMT_F16X4    = 6'd9;
    localparam logic [5:0] FMT_F32      = 6'd10;
    localparam logic [5:0] FMT_F32X3    = 6'd12;
    localparam logic [5:0] FMT_F32X4    = 6'd13;
    localparam logic [5:0] FMT_I32X4    = 6'd25;
    localparam logic [5:0] FMT_BC6      = 6'd27;
    localparam logic [5:0] FMT_BC1      = 6'd31;
    localparam logic [5:0] FMT_BC3      = 6'd32;
    localparam logic [5:0] FMT_F32_U8   = 6'd33;
    localparam logic [5:0] FMT_RGB10A2  = 6'd34;
    localparam logic [5:0] FMT_TOP_CODE = 6'd63;

    localparam logic [BYTES_W-1:0] BUF_FULL = {BYTES_W{1'b1}};

    // bytes per block for the valid codes
    localparam logic [4:0] FMT_BLOCK_BYTES [0:34] = '{
        5'd1, 5'd2, 5'd4, 5'd1, 5'd2, 5'd4,
        5'd2, 5'd4, 5'd6, 5'd8,
        5'd4, 5'd8, 5'd12, 5'd16,
        5'd2, 5'd4, 5'd6, 5'd8,
        5'd2, 5'd4, 5'd6, 5'd8,
        5'd4, 5'd8, 5'd12, 5'd16,
        5'd4,
        5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
        5'd8, 5'd4
    };

    typedef struct packed {
        logic [5:0]         fmt;
        dim_t               w;
        dim_t               h;
        dim_t               d;
        logic [LAYER_W-1:0] layers;
        logic [BYTES_W-1:0] buf_bytes;
    } tex_desc_t;

    typedef struct packed {
        logic [LVL_W-1:0]   mip_level;
        logic [BYTES_W-1:0] byte_offset;
        dim_t               level_width;
        dim_t               level_height;
        dim_t               level_depth;
        logic [BYTES_W-1:0] level_bytes;
        logic               bad_format;
        logic               last_level;
    } level_rec_t;

    class mip_scoreboard;
        level_rec_t pending_levels[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        function void queue_level(level_rec_t r);
            pending_levels = {pending_levels, r};
        endfunction

        // expands one accepted descriptor into its level records
        function void note_desc(tex_desc_t dsc);
            logic [63:0] w, h, d, mx, sz, offset, bw, bh, bpb;
            logic        bad;
            int          levels;
            level_rec_t  r;
            w = 64'(dsc.w);
            h = 64'(dsc.h);
            d = 64'(dsc.d);
            mx = w;
            if (h > mx)
                mx = h;
            if (d > mx)
                mx = d;
            levels = 1;
            while (levels < 31 && (mx >> levels) != 0)
                levels++;
            if (levels > MAX_LEVELS)
                levels = MAX_LEVELS;
            bad = (dsc.fmt >= NUM_FORMATS);
            bw = 1;
            bh = 1;
            bpb = 0;
            if (!bad)
            begin
                bpb = 64'(FMT_BLOCK_BYTES[dsc.fmt]);
                if (dsc.fmt >= FMT_BC_FIRST && dsc.fmt <= FMT_BC_LAST)
                begin
                    bw = 4;
                    bh = 4;
                end
            end
            offset = 0;
            for (int lvl = 0; lvl < levels; lvl++)
            begin
                sz = ((w + bw - 1) / bw) * ((h + bh - 1) / bh) * ((d == 0) ? 64'd1 : d) * bpb;
                r.mip_level    = LVL_W'(lvl);
                r.byte_offset  = offset[BYTES_W-1:0];
                r.level_width  = w[DIM_W-1:0];
                r.level_height = h[DIM_W-1:0];
                r.level_depth  = d[DIM_W-1:0];
                r.level_bytes  = sz[BYTES_W-1:0];
                r.bad_format   = bad;
                r.last_level   = 1'b0;
                offset = offset + sz * 64'(dsc.layers);
                if (offset >= 64'(dsc.buf_bytes) || lvl + 1 >= levels)
                begin
                    r.last_level = 1'b1;
                    queue_level(r);
                    break;
                end
                queue_level(r);
                w = ((w >> 1) == 0) ? 64'd1 : (w >> 1);
                h = ((h >> 1) == 0) ? 64'd1 : (h >> 1);
                d = ((d >> 1) == 0) ? 64'd1 : (d >> 1);
            end
        endfunction

        function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_rec(level_rec_t got);
            level_rec_t want;
            if (pending_levels.size() == 0)
            begin
                $error("record for level %0d with no descriptor waiting", got.mip_level);
                errors++;
                return;
            end
            want = pending_levels.pop_front();
            check_field("mip_level", want.mip_level, got.mip_level);
            check_field("byte_offset", want.byte_offset, got.byte_offset);
            check_field("level_width", want.level_width, got.level_width);
            check_field("level_height", want.level_height, got.level_height);
            check_field("level_depth", want.level_depth, got.level_depth);
            check_field("level_bytes", want.level_bytes, got.level_bytes);
            check_field("bad_format", want.bad_format, got.bad_format);
            check_field("last_level", want.last_level, got.last_level);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               desc_valid;
    logic               desc_ready;
    logic [5:0]         format;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [DIM_W-1:0]   depth;
    logic [LAYER_W-1:0] layer_count;
    logic [BYTES_W-1:0] buffer_bytes;
    logic               rec_valid;
    logic               rec_ready;
    logic [LVL_W-1:0]   mip_level;
    logic [BYTES_W-1:0] byte_offset;
    logic [DIM_W-1:0]   level_width;
    logic [DIM_W-1:0]   level_height;
    logic [DIM_W-1:0]   level_depth;
    logic [BYTES_W-1:0] level_bytes;
    logic               bad_format;
    logic               last_level;

    mip_scoreboard sb = new();
    bit            calm;
    int            sent_count;
    int            hold_left;
    bit            hold_done;
    int            quiet_cycles;

    texture_mip_chain_layout_unit #(.MAX_LEVELS(MAX_LEVELS)) uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // random value of 1..maxbits significant bits, top bit set
    function automatic logic [63:0] rand_len(int maxbits);
        int          nb;
        logic [63:0] v;
        nb = $urandom_range(1, maxbits);
        v = {$urandom, $urandom};
        return (v & ((64'd1 << nb) - 64'd1)) | (64'd1 << (nb - 1));
    endfunction

    function automatic tex_desc_t mk_desc(logic [5:0] f, dim_t w, dim_t h, dim_t d,
                                          logic [LAYER_W-1:0] l, logic [BYTES_W-1:0] b);
        tex_desc_t x;
        x.fmt = f;
        x.w = w;
        x.h = h;
        x.d = d;
        x.layers = l;
        x.buf_bytes = b;
        return x;
    endfunction

    function automatic dim_t rand_dim();
        logic [63:0] v;
        v = rand_len(DIM_W);
        if ($urandom_range(0, 99) < 4)
            v = 0;
        return v[DIM_W-1:0];
    endfunction

    function automatic tex_desc_t rand_desc();
        tex_desc_t   x;
        logic [63:0] v;
        x.fmt = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 34))
                                              : 6'($urandom_range(35, 63));
        x.w = rand_dim();
        x.h = rand_dim();
        x.d = ($urandom_range(0, 2) == 0) ? rand_dim() : dim_t'(1);
        v = rand_len(LAYER_W);
        x.layers = ($urandom_range(0, 99) < 3) ? '0 : v[LAYER_W-1:0];
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = BUF_FULL;
            2, 3: v = {$urandom, $urandom};
            default: v = rand_len(50);
        endcase
        x.buf_bytes = v[BYTES_W-1:0];
        return x;
    endfunction

    task automatic send_desc(tex_desc_t dsc);
        if (!calm && $urandom_range(0, 99) < 35)
        begin
            desc_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        desc_valid   <= 1'b1;
        format       <= dsc.fmt;
        width        <= dsc.w;
        height       <= dsc.h;
        depth        <= dsc.d;
        layer_count  <= dsc.layers;
        buffer_bytes <= dsc.buf_bytes;
        @(posedge clk);
        while (!desc_ready)
            @(posedge clk);
        sb.note_desc(dsc);
        sent_count++;
    endtask

    // sender stops offering and waits for every record to drain
    task automatic drain_records();
        desc_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        desc_valid   <= 1'b0;
        format       <= '0;
        width        <= '0;
        height       <= '0;
        depth        <= '0;
        layer_count  <= '0;
        buffer_bytes <= '0;
        calm         = 1'b0;
        sent_count   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_desc(mk_desc(FMT_UNORM8, 1, 1, 1, 1, BUF_FULL));
        send_desc(mk_desc(FMT_F32X4, 32767, 32767, 1, 4095, BUF_FULL));
        send_desc(mk_desc(FMT_BC6, 5, 3, 1, 1, BUF_FULL));
        send_desc(mk_desc(FMT_BC3, 16384, 16384, 16384, 1, BUF_FULL));
        send_desc(mk_desc(FMT_BC1, 1, 1, 1, 2, BUF_FULL));
        send_desc(mk_desc(FMT_RGB10A2, 300, 200, 1, 6, BUF_FULL));
        // unknown codes: zero size, offset never moves
        send_desc(mk_desc(NUM_FORMATS, 64, 64, 1, 1, BUF_FULL));
        send_desc(mk_desc(FMT_TOP_CODE, 100, 7, 3, 5, '0));
        // zero dimensions
        send_desc(mk_desc(FMT_UNORM8X4, 0, 16, 1, 1, BUF_FULL));
        send_desc(mk_desc(FMT_UNORM8X4, 0, 0, 0, 1, BUF_FULL));
        send_desc(mk_desc(FMT_F16X4, 8, 8, 0, 2, BUF_FULL));
        // zero layers keeps the offset at zero
        send_desc(mk_desc(FMT_UNORM8X2, 128, 64, 8, 0, 1));
        send_desc(mk_desc(FMT_F32, 256, 256, 1, 1, '0));
        // buffer exactly filled by the base level, then one byte more
        send_desc(mk_desc(FMT_UNORM8, 1024, 1024, 1, 1, 1024 * 1024));
        send_desc(mk_desc(FMT_UNORM8, 1024, 1024, 1, 1, 1024 * 1024 + 1));
        send_desc(mk_desc(FMT_I32X4, 64, 32, 16, 6, BUF_FULL));
        send_desc(mk_desc(FMT_SNORM8, 1, 1, 32767, 1, BUF_FULL));
        send_desc(mk_desc(FMT_F32X3, 3, 20000, 5, 3, BUF_FULL));
        send_desc(mk_desc(FMT_F32X4, 32767, 32767, 32767, 4095, BUF_FULL));
        send_desc(mk_desc(FMT_F32_U8, 7, 9, 3, 4095, 60'h0_1234_5678_9abc));

        for (int i = 0; i < RANDOM_DESC; i++)
        begin
            calm = (i >= 60 && i < 130);
            if (i == 220)
                drain_records();
            send_desc(rand_desc());
        end
        drain_records();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, a quiet stretch, and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (rec_valid && rec_ready)
                sb.check_rec({mip_level, byte_offset, level_width, level_height,
                              level_depth, level_bytes, bad_format, last_level});
            if (!hold_done && sent_count >= 170)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rec_ready <= 1'b0;
            end
            else
                rec_ready <= calm || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (desc_valid && desc_ready) || (rec_valid && rec_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
